// File: rtl/congestion_window_controller_assert.svh
// ----------------------------------------------------------------------------
// Congestion window controller assertion macros
// Shared property shorthands for the checker: an immediate implication and a
// next-cycle implication, both clocked and masked during reset.
// ----------------------------------------------------------------------------
`ifndef CONGESTION_WINDOW_CONTROLLER_ASSERT_SVH
`define CONGESTION_WINDOW_CONTROLLER_ASSERT_SVH

// Same-cycle implication
`define CWC_ASSERT_NOW(name, clk, rst_n, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication
`define CWC_ASSERT_NEXT(name, clk, rst_n, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

// File: rtl/cwc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Congestion window controller package
// Beat types, opcodes, register indexes, reset values and control structs
// shared by the controller modules and its checker.
// ----------------------------------------------------------------------------
package cwc_pkg;

  // Default parameter values
  localparam int SEQ_WIDTH_DEF = 16;
  localparam int FRAC_BITS_DEF = 8;

  // Field widths
  localparam int OP_W     = 2;
  localparam int SEQ_F_W  = 16;
  localparam int WIN_W    = 8;
  localparam int WHOLE_W  = 16;
  localparam int DUP_W    = 3;

  // Event opcodes
  localparam logic [OP_W-1:0] OP_ACK     = 2'd0;
  localparam logic [OP_W-1:0] OP_TIMEOUT = 2'd1;
  localparam logic [OP_W-1:0] OP_SEND    = 2'd2;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_SEGMENTS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_WINDOW = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_WINDOW     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_RX_WINDOW = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DUP_THRESHOLD  = 3'd4;

  // Register reset values
  localparam logic [SEQ_F_W-1:0] RST_TOTAL_SEG = 16'd1;
  localparam logic [WIN_W-1:0]   RST_INIT_WIN  = 8'd3;
  localparam logic [WIN_W-1:0]   RST_MIN_WIN   = 8'd3;
  localparam logic [WIN_W-1:0]   RST_INIT_RWIN = 8'd10;
  localparam logic [DUP_W-1:0]   RST_DUP_THR   = 3'd3;

  // Misc constants
  localparam logic [WHOLE_W-1:0] SSTHRESH_NONE = 16'hFFFF;
  localparam logic [DUP_W-1:0]   DUP_MAX       = 3'd7;
  localparam logic [WIN_W-1:0]   FREED_MAX     = 8'd255;

  // Input beat
  typedef struct packed {
    logic [OP_W-1:0]    opcode;
    logic [SEQ_F_W-1:0] ack_count;
    logic [WIN_W-1:0]   advertised_window;
  } in_item_t;

  // Result beat
  typedef struct packed {
    logic               send_granted;
    logic [SEQ_F_W-1:0] send_seq;
    logic [SEQ_F_W-1:0] acked_total;
    logic [SEQ_F_W-1:0] next_seq;
    logic [WIN_W-1:0]   send_window;
    logic [WHOLE_W-1:0] cwnd_whole;
    logic [WHOLE_W-1:0] slow_start_limit;
    logic               fast_retransmit;
    logic [WIN_W-1:0]   freed_slots;
    logic               transfer_done;
  } out_item_t;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DIVIDE,
    ST_FINISH
  } cwc_state_e;

  // Datapath status seen by the sequencer
  typedef struct packed {
    logic in_valid;
    logic need_div;
    logic div_done;
    logic out_free;
  } stat_t;

  // Sequencer commands to the datapath
  typedef struct packed {
    logic busy;
    logic item_load;
    logic div_start;
    logic commit;
  } ctrl_t;

endpackage

// File: rtl/cwc_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Congestion window controller serial divider
// Restoring divider: one compare and subtract per cycle, one quotient bit per
// step, MSB first. Quotient is valid while done_o is high and holds after.
// ----------------------------------------------------------------------------
module cwc_div import cwc_pkg::*; #(
  parameter int DIVIDEND_W = SEQ_WIDTH_DEF + FRAC_BITS_DEF,
  parameter int DIVISOR_W  = WHOLE_W
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [DIVIDEND_W-1:0] dividend_i,
  input  logic [DIVISOR_W-1:0]  divisor_i,
  output logic                  done_o,
  output logic [DIVIDEND_W-1:0] quotient_o
);

  localparam int CNT_W = $clog2(DIVIDEND_W + 1);

  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [DIVIDEND_W-1:0] num_q, num_d;
  logic [DIVIDEND_W-1:0] quo_q, quo_d;
  logic [DIVISOR_W-1:0]  den_q, den_d;
  logic [DIVISOR_W-1:0]  rem_q, rem_d;

  logic [DIVISOR_W:0]    trial;
  logic                  fits;

  // Shared step: shift in next dividend bit, trial subtract
  assign trial = {rem_q, num_q[DIVIDEND_W-1]};
  assign fits  = (trial >= {1'b0, den_q});

  // Step control
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    num_d  = num_q;
    quo_d  = quo_q;
    den_d  = den_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(DIVIDEND_W);
      num_d  = dividend_i;
      den_d  = divisor_i;
      rem_d  = '0;
      quo_d  = '0;
    end else if (busy_q) begin
      rem_d = fits ? DIVISOR_W'(trial - {1'b0, den_q}) : DIVISOR_W'(trial);
      num_d = num_q << 1;
      quo_d = {quo_q[DIVIDEND_W-2:0], fits};
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Operand and partial result registers
  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    quo_q <= quo_d;
    den_q <= den_d;
    rem_q <= rem_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// File: rtl/cwc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Congestion window controller sequencer
// Walks one event through load, evaluate, optional divide and commit, and
// holds the input side off until the result beat is placed.
// ----------------------------------------------------------------------------
module cwc_ctrl import cwc_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  stat_t stat_i,
  output ctrl_t ctrl_o
);

  cwc_state_e state_q, state_d;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (stat_i.in_valid) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        state_d = stat_i.need_div ? ST_DIVIDE : ST_FINISH;
      end
      ST_DIVIDE: begin
        if (stat_i.div_done) state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (stat_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    ctrl_o = '0;
    case (state_q)
      ST_IDLE: begin
        ctrl_o.item_load = stat_i.in_valid;
      end
      ST_EXEC: begin
        ctrl_o.busy      = 1'b1;
        ctrl_o.div_start = stat_i.need_div;
      end
      ST_DIVIDE: begin
        ctrl_o.busy = 1'b1;
      end
      ST_FINISH: begin
        ctrl_o.busy   = 1'b1;
        ctrl_o.commit = stat_i.out_free;
      end
      default: ctrl_o.busy = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: rtl/congestion_window_controller.sv
`timescale 1ns / 1ps
// Flow: an accepted event is loaded into the event register, evaluated in the
// exec state and committed to the result register in the finish state once the
// result slot is free; a new ack in congestion avoidance runs the divider first.
// The input is held off from accept until the commit, so one event is in flight.
// Reset: async active low; registers and window state return to defaults.
// A write to a valid index reloads the window state from the register values.
// ----------------------------------------------------------------------------
// Congestion window controller
// Sender-side sliding-window congestion control: acks, timeouts and send
// requests update cwnd (fixed point), ssthresh, ack and send pointers.
// ----------------------------------------------------------------------------
module congestion_window_controller import cwc_pkg::*; #(
  parameter int SEQ_WIDTH = SEQ_WIDTH_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Event channel
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_item_t              in_item_i,
  // Result channel
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_item_t             out_item_o,
  // Configuration port
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int SW     = SEQ_WIDTH;
  localparam int CWND_W = WHOLE_W + FRAC_BITS;
  localparam int DW     = SEQ_WIDTH + FRAC_BITS;
  localparam int SUM_W  = ((DW > CWND_W) ? DW : CWND_W) + 1;
  localparam int CMP_W  = (SW > SEQ_F_W) ? SW : SEQ_F_W;

  localparam logic [CWND_W-1:0] CWND_MAX = '1;
  localparam logic [CWND_W-1:0] RST_CWND = CWND_W'(RST_INIT_WIN) << FRAC_BITS;
  localparam logic [WIN_W-1:0]  RST_WIN  =
    (RST_INIT_WIN < RST_INIT_RWIN) ? RST_INIT_WIN : RST_INIT_RWIN;

  // Configuration registers
  logic [SEQ_F_W-1:0] total_q, total_d;
  logic [WIN_W-1:0]   init_win_q, init_win_d;
  logic [WIN_W-1:0]   min_win_q, min_win_d;
  logic [WIN_W-1:0]   init_rwin_q, init_rwin_d;
  logic [DUP_W-1:0]   dup_thr_q, dup_thr_d;
  logic               cfg_hit;

  // Window state
  logic [CWND_W-1:0]  cwnd_q, cwnd_d;
  logic [WHOLE_W-1:0] ssth_q, ssth_d;
  logic [SW-1:0]      acked_q, acked_d;
  logic [SW-1:0]      next_q, next_d;
  logic [WIN_W-1:0]   win_q, win_d;
  logic [WIN_W-1:0]   peer_q, peer_d;
  logic [DUP_W-1:0]   dup_q, dup_d;

  // Event and result
  in_item_t           item_q;
  out_item_t          out_q;
  logic               out_valid_q, out_valid_d;

  // Sequencer link
  stat_t              stat;
  ctrl_t              ctrl;

  // Event evaluation
  logic [SW-1:0]      ack_m;
  logic               new_ack;
  logic [SW-1:0]      delta;
  logic               slow;
  logic [WHOLE_W-1:0] whole;
  logic [WHOLE_W-1:0] divisor;
  logic [DW-1:0]      delta_fx;
  logic [DW-1:0]      div_quo;
  logic               div_done;
  logic [DW-1:0]      grow;
  logic [SUM_W-1:0]   cwnd_sum;
  logic [CWND_W-1:0]  cwnd_sat;
  logic [DUP_W-1:0]   dup_inc;
  logic               dup_fire;
  logic [WIN_W-1:0]   half_win;
  logic [SW-1:0]      inflight;
  logic               send_ok;
  logic [WIN_W-1:0]   send_win;

  logic [CWND_W-1:0]  evt_cwnd;
  logic [WHOLE_W-1:0] evt_ssth;
  logic [SW-1:0]      evt_acked;
  logic [SW-1:0]      evt_next;
  logic [WIN_W-1:0]   evt_win;
  logic [WIN_W-1:0]   evt_peer;
  logic [DUP_W-1:0]   evt_dup;
  logic               evt_grant;
  logic [SW-1:0]      evt_seq;
  logic               evt_fast;
  logic [WIN_W-1:0]   evt_freed;

  // --------------------------------------------------------------------------
  // Configuration writes
  assign cfg_hit = cfg_we_i &&
                   (cfg_idx_i inside {[CFG_TOTAL_SEGMENTS:CFG_DUP_THRESHOLD]});

  always_comb begin
    total_d     = total_q;
    init_win_d  = init_win_q;
    min_win_d   = min_win_q;
    init_rwin_d = init_rwin_q;
    dup_thr_d   = dup_thr_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_TOTAL_SEGMENTS: total_d     = cfg_data_i[SEQ_F_W-1:0];
        CFG_INITIAL_WINDOW: init_win_d  = cfg_data_i[WIN_W-1:0];
        CFG_MIN_WINDOW:     min_win_d   = cfg_data_i[WIN_W-1:0];
        CFG_INIT_RX_WINDOW: init_rwin_d = cfg_data_i[WIN_W-1:0];
        CFG_DUP_THRESHOLD:  dup_thr_d   = cfg_data_i[DUP_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q     <= RST_TOTAL_SEG;
      init_win_q  <= RST_INIT_WIN;
      min_win_q   <= RST_MIN_WIN;
      init_rwin_q <= RST_INIT_RWIN;
      dup_thr_q   <= RST_DUP_THR;
    end else begin
      total_q     <= total_d;
      init_win_q  <= init_win_d;
      min_win_q   <= min_win_d;
      init_rwin_q <= init_rwin_d;
      dup_thr_q   <= dup_thr_d;
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer
  assign stat.in_valid = in_valid_i;
  assign stat.need_div = (item_q.opcode == OP_ACK) && new_ack && !slow;
  assign stat.div_done = div_done;
  assign stat.out_free = !out_valid_q || !out_stall_i;

  cwc_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctrl_o (ctrl)
  );

  assign in_stall_o = ctrl.busy;

  // Event beat register
  always_ff @(posedge clk_i) begin
    if (ctrl.item_load) item_q <= in_item_i;
  end

  // --------------------------------------------------------------------------
  // Ack growth: slow start adds delta, avoidance adds delta / floor(cwnd)
  assign ack_m    = SW'(item_q.ack_count);
  assign new_ack  = (ack_m > acked_q);
  assign delta    = ack_m - acked_q;
  assign slow     = (WHOLE_W'(win_q) <= ssth_q);
  assign whole    = cwnd_q[CWND_W-1:FRAC_BITS];
  assign divisor  = (whole == '0) ? WHOLE_W'(1) : whole;
  assign delta_fx = {delta, {FRAC_BITS{1'b0}}};

  cwc_div #(
    .DIVIDEND_W (DW),
    .DIVISOR_W  (WHOLE_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (ctrl.div_start),
    .dividend_i (delta_fx),
    .divisor_i  (divisor),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  assign grow     = slow ? delta_fx : div_quo;
  assign cwnd_sum = SUM_W'(cwnd_q) + SUM_W'(grow);
  assign cwnd_sat = (cwnd_sum > SUM_W'(CWND_MAX)) ? CWND_MAX : CWND_W'(cwnd_sum);

  // Duplicate ack count and loss window
  assign dup_inc  = (dup_q < DUP_MAX) ? dup_q + DUP_W'(1) : dup_q;
  assign dup_fire = (dup_inc == dup_thr_q);
  assign half_win = win_q >> 1;

  // Send check
  assign inflight = next_q - acked_q;
  assign send_ok  = (CMP_W'(inflight) < CMP_W'(win_q)) &&
                    (CMP_W'(next_q) < CMP_W'(total_q));
  assign send_win = (whole < WHOLE_W'(peer_q)) ? whole[WIN_W-1:0] : peer_q;

  // State after this event
  always_comb begin
    evt_cwnd  = cwnd_q;
    evt_ssth  = ssth_q;
    evt_acked = acked_q;
    evt_next  = next_q;
    evt_win   = win_q;
    evt_peer  = peer_q;
    evt_dup   = dup_q;
    evt_grant = 1'b0;
    evt_seq   = '0;
    evt_fast  = 1'b0;
    evt_freed = '0;
    case (item_q.opcode)
      OP_ACK: begin
        evt_peer = item_q.advertised_window;
        if (new_ack) begin
          evt_acked = ack_m;
          if (next_q < ack_m) evt_next = ack_m;
          evt_dup   = '0;
          evt_freed = (delta > SW'(FREED_MAX)) ? FREED_MAX : delta[WIN_W-1:0];
          evt_cwnd  = cwnd_sat;
        end else begin
          evt_dup = dup_inc;
          if (dup_fire) begin
            evt_next = acked_q;
            evt_ssth = (half_win > min_win_q) ? WHOLE_W'(half_win)
                                              : WHOLE_W'(min_win_q);
            evt_win  = min_win_q;
            evt_fast = 1'b1;
          end
        end
      end
      OP_TIMEOUT: begin
        evt_next = acked_q;
        if (win_q > min_win_q) evt_win = half_win;
      end
      OP_SEND: begin
        if (send_ok) begin
          evt_grant = 1'b1;
          evt_seq   = next_q;
          evt_next  = next_q + SW'(1);
          evt_win   = send_win;
        end
      end
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // Window state: restart on config write, update on commit
  always_comb begin
    cwnd_d  = cwnd_q;
    ssth_d  = ssth_q;
    acked_d = acked_q;
    next_d  = next_q;
    win_d   = win_q;
    peer_d  = peer_q;
    dup_d   = dup_q;
    if (cfg_hit) begin
      cwnd_d  = CWND_W'(init_win_d) << FRAC_BITS;
      ssth_d  = SSTHRESH_NONE;
      acked_d = '0;
      next_d  = '0;
      win_d   = (init_win_d < init_rwin_d) ? init_win_d : init_rwin_d;
      peer_d  = init_rwin_d;
      dup_d   = '0;
    end else if (ctrl.commit) begin
      cwnd_d  = evt_cwnd;
      ssth_d  = evt_ssth;
      acked_d = evt_acked;
      next_d  = evt_next;
      win_d   = evt_win;
      peer_d  = evt_peer;
      dup_d   = evt_dup;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cwnd_q  <= RST_CWND;
      ssth_q  <= SSTHRESH_NONE;
      acked_q <= '0;
      next_q  <= '0;
      win_q   <= RST_WIN;
      peer_q  <= RST_INIT_RWIN;
      dup_q   <= '0;
    end else begin
      cwnd_q  <= cwnd_d;
      ssth_q  <= ssth_d;
      acked_q <= acked_d;
      next_q  <= next_d;
      win_q   <= win_d;
      peer_q  <= peer_d;
      dup_q   <= dup_d;
    end
  end

  // --------------------------------------------------------------------------
  // Result beat register
  assign out_valid_d = ctrl.commit || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.commit) begin
      out_q.send_granted     <= evt_grant;
      out_q.send_seq         <= SEQ_F_W'(evt_seq);
      out_q.acked_total      <= SEQ_F_W'(evt_acked);
      out_q.next_seq         <= SEQ_F_W'(evt_next);
      out_q.send_window      <= evt_win;
      out_q.cwnd_whole       <= evt_cwnd[CWND_W-1:FRAC_BITS];
      out_q.slow_start_limit <= evt_ssth;
      out_q.fast_retransmit  <= evt_fast;
      out_q.freed_slots      <= evt_freed;
      out_q.transfer_done    <= (CMP_W'(evt_acked) >= CMP_W'(total_q));
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

// File: rtl/cwc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Congestion window controller checker
// Port-level properties of the controller, attached by bind.
// ----------------------------------------------------------------------------
`include "congestion_window_controller_assert.svh"

module cwc_checker import cwc_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_item_t out_item_o
);

  // One event at a time: busy right after a beat is taken
  `CWC_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o, "input not held off after accept")

  // A result beat without a send grant reports sequence zero
  `CWC_ASSERT_NOW(a_no_grant_seq_zero, clk_i, rst_ni, out_valid_o && !out_item_o.send_granted, out_item_o.send_seq == '0, "send_seq nonzero without grant")

  // Fast retransmit rewinds the send pointer and frees nothing
  `CWC_ASSERT_NOW(a_fast_rewind, clk_i, rst_ni, out_valid_o && out_item_o.fast_retransmit, (out_item_o.next_seq == out_item_o.acked_total) && (out_item_o.freed_slots == '0), "fast retransmit without rewind")

  // Stalled result beat holds
  `CWC_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(out_item_o), "stalled result beat changed")

endmodule

bind congestion_window_controller cwc_checker u_cwc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);

// File: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Congestion window controller testbench
// Drives ack, timeout and send events into the controller, predicts every
// result beat with a cycle-free model of the window state, and compares each
// result field by field. Directed events come first, then register settings
// with random, mostly well-formed ack/send traffic and random idling.
// ----------------------------------------------------------------------------
module tb;
  import cwc_pkg::*;

  localparam int          FRAC_W       = FRAC_BITS_DEF;
  localparam int          CWND_W       = 16 + FRAC_W;
  localparam logic [31:0] CWND_MAX     = (32'd1 << CWND_W) - 32'd1;
  localparam logic [OP_W-1:0]      OP_UNUSED   = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BAD_IDX = 3'd5;
  localparam int          IDLE_PCT     = 24;
  localparam int          CYCLE_LIMIT  = 600000;
  localparam int          DRAIN_CYCLES = 40;

  // DUT signals; the inputs are all known from time zero
  logic                  clk_i     = 1'b0;
  logic                  rst_ni    = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall_o;
  in_item_t              in_item   = '0;
  logic                  out_valid_o;
  logic                  out_stall = 1'b0;
  out_item_t             out_item_o;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx   = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  congestion_window_controller dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .out_item_o  (out_item_o),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  // Register copies
  logic [SEQ_F_W-1:0] cfg_total;
  logic [WIN_W-1:0]   cfg_init_win;
  logic [WIN_W-1:0]   cfg_min_win;
  logic [WIN_W-1:0]   cfg_init_rwin;
  logic [DUP_W-1:0]   cfg_dup_thr;

  // Window state copies
  logic [CWND_W-1:0]  cwnd_q;
  logic [WHOLE_W-1:0] ssthresh_q;
  logic [SEQ_F_W-1:0] acked_q;
  logic [SEQ_F_W-1:0] next_q;
  logic [WIN_W-1:0]   win_q;
  logic [WIN_W-1:0]   peer_win_q;
  logic [DUP_W-1:0]   dup_q;

  in_item_t  pending_events[$];
  out_item_t expected_results[$];
  int        mismatches = 0;
  int        cycles     = 0;
  logic      no_idle    = 1'b0;
  int        gen_acked;
  int        gen_sent;

  // Clock
  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Reload window state from the registers
  task automatic restart_window_state();
    cwnd_q     = CWND_W'(cfg_init_win) << FRAC_W;
    ssthresh_q = SSTHRESH_NONE;
    acked_q    = '0;
    next_q     = '0;
    win_q      = (cfg_init_win < cfg_init_rwin) ? cfg_init_win : cfg_init_rwin;
    peer_win_q = cfg_init_rwin;
    dup_q      = '0;
  endtask

  // Window state update for one event, returns the result beat
  function automatic out_item_t apply_event(in_item_t ev);
    out_item_t          r;
    logic [16:0]        delta;
    logic [31:0]        grow;
    logic [31:0]        sum;
    logic [WHOLE_W-1:0] whole;
    logic [SEQ_F_W-1:0] inflight;
    logic [WIN_W-1:0]   half;
    r = '0;
    whole = cwnd_q[FRAC_W +: WHOLE_W];
    case (ev.opcode)
      OP_ACK: begin
        peer_win_q = ev.advertised_window;
        if (ev.ack_count > acked_q) begin
          delta   = 17'(ev.ack_count) - 17'(acked_q);
          acked_q = ev.ack_count;
          if (next_q < acked_q) next_q = acked_q;
          dup_q = '0;
          r.freed_slots = (delta > 17'd255) ? FREED_MAX : delta[WIN_W-1:0];
          if ({8'd0, win_q} <= ssthresh_q) begin
            grow = {15'd0, delta} << FRAC_W;
          end else begin
            // congestion avoidance: zero whole part divides as one
            if (whole == '0) whole = 16'd1;
            grow = ({15'd0, delta} << FRAC_W) / 32'(whole);
          end
          sum    = 32'(cwnd_q) + grow;
          cwnd_q = (sum > CWND_MAX) ? CWND_MAX[CWND_W-1:0] : sum[CWND_W-1:0];
        end else begin
          if (dup_q < DUP_MAX) dup_q = dup_q + 3'd1;
          if (dup_q == cfg_dup_thr) begin
            half       = win_q >> 1;
            next_q     = acked_q;
            ssthresh_q = {8'd0, (half > cfg_min_win) ? half : cfg_min_win};
            win_q      = cfg_min_win;
            r.fast_retransmit = 1'b1;
          end
        end
      end
      OP_TIMEOUT: begin
        next_q = acked_q;
        if (win_q > cfg_min_win) win_q = win_q >> 1;
      end
      OP_SEND: begin
        inflight = next_q - acked_q;
        if (inflight < {8'd0, win_q} && next_q < cfg_total) begin
          r.send_granted = 1'b1;
          r.send_seq     = next_q;
          next_q         = next_q + 16'd1;
          win_q = (whole < {8'd0, peer_win_q}) ? whole[WIN_W-1:0] : peer_win_q;
        end
      end
      default: ;
    endcase
    r.acked_total      = acked_q;
    r.next_seq         = next_q;
    r.send_window      = win_q;
    r.cwnd_whole       = cwnd_q[FRAC_W +: WHOLE_W];
    r.slow_start_limit = ssthresh_q;
    r.transfer_done    = (acked_q >= cfg_total);
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    $display("[%0t] mismatch %s: got %0h expected %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  task automatic check_field(string what, logic [15:0] got, logic [15:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  task automatic compare_result(out_item_t got, out_item_t want);
    check_field("send_granted", 16'(got.send_granted), 16'(want.send_granted));
    check_field("send_seq", got.send_seq, want.send_seq);
    check_field("acked_total", got.acked_total, want.acked_total);
    check_field("next_seq", got.next_seq, want.next_seq);
    check_field("send_window", 16'(got.send_window), 16'(want.send_window));
    check_field("cwnd_whole", got.cwnd_whole, want.cwnd_whole);
    check_field("slow_start_limit", got.slow_start_limit, want.slow_start_limit);
    check_field("fast_retransmit", 16'(got.fast_retransmit), 16'(want.fast_retransmit));
    check_field("freed_slots", 16'(got.freed_slots), 16'(want.freed_slots));
    check_field("transfer_done", 16'(got.transfer_done), 16'(want.transfer_done));
  endtask

  // Event driver: next beat once the current one is taken
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall_o) begin
        expected_results.push_back(apply_event(in_item));
      end
      if (!in_valid || !in_stall_o) begin
        if (pending_events.size() != 0 &&
            (no_idle || $urandom_range(0, 99) >= IDLE_PCT)) begin
          in_item  <= pending_events.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor with random back-pressure
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result beat", 16'd0, 16'd0);
        end else begin
          compare_result(out_item_o, expected_results.pop_front());
        end
      end
      out_stall <= !no_idle && ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  // Run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("congestion_window_controller verification failed");
      $finish;
    end
  end

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    case (idx)
      CFG_TOTAL_SEGMENTS: cfg_total     = value;
      CFG_INITIAL_WINDOW: cfg_init_win  = value[WIN_W-1:0];
      CFG_MIN_WINDOW:     cfg_min_win   = value[WIN_W-1:0];
      CFG_INIT_RX_WINDOW: cfg_init_rwin = value[WIN_W-1:0];
      CFG_DUP_THRESHOLD:  cfg_dup_thr   = value[DUP_W-1:0];
      default: ;
    endcase
    // unknown index leaves the transfer running
    if (idx <= CFG_DUP_THRESHOLD) restart_window_state();
  endtask

  task automatic configure(logic [15:0] total, logic [7:0] iw, logic [7:0] mw,
                           logic [7:0] rw, logic [2:0] thr);
    write_register(CFG_TOTAL_SEGMENTS, total);
    write_register(CFG_INITIAL_WINDOW, 16'(iw));
    write_register(CFG_MIN_WINDOW, 16'(mw));
    write_register(CFG_INIT_RX_WINDOW, 16'(rw));
    write_register(CFG_DUP_THRESHOLD, 16'(thr));
    gen_acked = 0;
    gen_sent  = 0;
    @(negedge clk_i);
  endtask

  task automatic push_event(logic [OP_W-1:0] op, logic [SEQ_F_W-1:0] ack,
                            logic [WIN_W-1:0] adv);
    in_item_t ev;
    ev.opcode            = op;
    ev.ack_count         = ack;
    ev.advertised_window = adv;
    pending_events.push_back(ev);
  endtask

  // Mostly in-order sends and acks, with dup bursts, timeouts and noise
  task automatic queue_random_events(int count);
    int               n;
    int               pick;
    int               room;
    int               burst;
    int               ack;
    logic [WIN_W-1:0] adv;
    n = 0;
    while (n < count) begin
      pick = $urandom_range(0, 99);
      adv  = ($urandom_range(0, 4) == 0) ? WIN_W'($urandom_range(0, 255))
                                         : WIN_W'($urandom_range(4, 64));
      if (pick < 45) begin
        push_event(OP_SEND, SEQ_F_W'($urandom), adv);
        if (gen_sent < 65535) gen_sent++;
        n++;
      end else if (pick < 75) begin
        room = gen_sent - gen_acked;
        if (room > 0) gen_acked += $urandom_range(1, (room < 4) ? room : 4);
        push_event(OP_ACK, SEQ_F_W'(gen_acked), adv);
        n++;
      end else if (pick < 88) begin
        burst = $urandom_range(1, 8);
        repeat (burst) begin
          ack = (gen_acked > 0 && $urandom_range(0, 3) == 0) ? gen_acked - 1 : gen_acked;
          push_event(OP_ACK, SEQ_F_W'(ack), adv);
        end
        n += burst;
      end else if (pick < 93) begin
        gen_sent = gen_acked;
        push_event(OP_TIMEOUT, SEQ_F_W'($urandom), WIN_W'($urandom));
        n++;
      end else if (pick < 97) begin
        ack = $urandom_range(0, 65535);
        if (ack > gen_acked) gen_acked = ack;
        if (gen_sent < gen_acked) gen_sent = gen_acked;
        push_event(OP_ACK, SEQ_F_W'(ack), WIN_W'($urandom));
        n++;
      end else begin
        push_event(OP_UNUSED, SEQ_F_W'($urandom), WIN_W'($urandom));
        n++;
      end
    end
  endtask

  task automatic wait_drained();
    while (pending_events.size() != 0 || expected_results.size() != 0 || in_valid)
      @(negedge clk_i);
  endtask

  task automatic random_phase(logic [15:0] total, logic [7:0] iw, logic [7:0] mw,
                              logic [7:0] rw, logic [2:0] thr, int count);
    configure(total, iw, mw, rw, thr);
    queue_random_events(count);
    wait_drained();
  endtask

  // Stimulus sequence
  initial begin
    cfg_total     = RST_TOTAL_SEG;
    cfg_init_win  = RST_INIT_WIN;
    cfg_min_win   = RST_MIN_WIN;
    cfg_init_rwin = RST_INIT_RWIN;
    cfg_dup_thr   = RST_DUP_THR;
    restart_window_state();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset settings: grant, refusal, dup run to fast retransmit, saturation
    push_event(OP_SEND, 16'd0, 8'd0);
    push_event(OP_SEND, 16'd0, 8'd0);
    push_event(OP_ACK, 16'd1, 8'd0);
    push_event(OP_ACK, 16'd1, 8'd255);
    push_event(OP_ACK, 16'd0, 8'd128);
    push_event(OP_ACK, 16'd1, 8'd10);
    push_event(OP_ACK, 16'd1, 8'd10);
    push_event(OP_TIMEOUT, 16'hFFFF, 8'hFF);
    push_event(OP_UNUSED, 16'hFFFF, 8'hFF);
    push_event(OP_ACK, 16'hFFFF, 8'd255);
    push_event(OP_SEND, 16'hFFFF, 8'hFF);
    push_event(OP_TIMEOUT, 16'd0, 8'd0);
    wait_drained();

    // Unknown index is ignored
    write_register(CFG_BAD_IDX, 16'hFFFF);

    // Wide settings: threshold of one, congestion avoidance, window halving
    configure(16'hFFFF, 8'd255, 8'd1, 8'd255, 3'd1);
    push_event(OP_SEND, 16'd0, 8'd0);
    push_event(OP_SEND, 16'd0, 8'd0);
    push_event(OP_SEND, 16'd0, 8'd0);
    push_event(OP_ACK, 16'd2, 8'd200);
    push_event(OP_ACK, 16'd2, 8'd200);
    push_event(OP_SEND, 16'd0, 8'd0);
    push_event(OP_ACK, 16'd200, 8'd200);
    push_event(OP_TIMEOUT, 16'd0, 8'd0);
    push_event(OP_SEND, 16'd0, 8'd0);
    push_event(OP_ACK, 16'hFFFF, 8'd5);
    wait_drained();

    // Random traffic over several register settings
    random_phase(16'd200, 8'd10, 8'd2, 8'd32, 3'd3, 125);
    random_phase(16'hFFFF, 8'd255, 8'd255, 8'd255, 3'd7, 125);
    random_phase(16'd1, 8'd1, 8'd1, 8'd0, 3'd1, 125);
    random_phase(16'd0, 8'd0, 8'd0, 8'd17, 3'd0, 125);
    no_idle = 1'b1;
    random_phase(16'd500, 8'd4, 8'd3, 8'd64, 3'd2, 125);
    no_idle = 1'b0;
    repeat (2) begin
      random_phase(16'($urandom_range(20, 1000)), 8'($urandom_range(1, 255)),
                   8'($urandom_range(1, 16)), 8'($urandom_range(0, 255)),
                   3'($urandom_range(1, 7)), 125);
    end
    random_phase(16'd100, 8'd3, 8'd3, 8'd10, 3'd3, 125);

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (expected_results.size() != 0)
      report_mismatch("results never arrived", 16'(expected_results.size()), 16'd0);
    if (mismatches == 0) begin
      $display("congestion_window_controller verification clean");
    end else begin
      $display("congestion_window_controller verification failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl
rtl/cwc_pkg.sv
rtl/cwc_div.sv
rtl/cwc_ctrl.sv
rtl/congestion_window_controller.sv
rtl/cwc_checker.sv
sim/tb.sv
